// ===== hdl/vpa_pkg.sv =====
// ----------------------------------------------------------------------------
// vpa_pkg
// Shared types and constants for the variable partition allocator.
// ----------------------------------------------------------------------------
package vpa_pkg;

  localparam int OWNED_ENTRIES = 16;
  localparam int FREE_ENTRIES  = 17;
  localparam int ADDR_BITS     = 16;
  localparam int OWN_IDX_BITS  = $clog2(OWNED_ENTRIES);
  localparam int FREE_IDX_BITS = $clog2(FREE_ENTRIES);
  localparam int OWN_CNT_BITS  = $clog2(OWNED_ENTRIES + 1);
  localparam int FREE_CNT_BITS = $clog2(FREE_ENTRIES + 1);

  localparam logic [15:0] RESET_TOTAL = 16'd1024;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_SIZE = 3'd1;
  localparam logic [2:0] ST_NO_FIT   = 3'd2;
  localparam logic [2:0] ST_UNKNOWN  = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  localparam logic [1:0] FIT_BEST  = 2'd0;
  localparam logic [1:0] FIT_WORST = 2'd1;
  localparam logic [1:0] FIT_FIRST = 2'd2;

  localparam logic OP_CREATE = 1'b0;
  localparam logic OP_KILL   = 1'b1;

  localparam logic CFG_FIT_POLICY = 1'b0;
  localparam logic CFG_TOTAL_SIZE = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [15:0] request_size;
    logic [15:0] target_owner;
  } vpa_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] owner_id;
    logic [15:0] base_address;
  } vpa_out_t;

endpackage

// ===== hdl/variable_partition_allocator.sv =====
// ----------------------------------------------------------------------------
// variable_partition_allocator
// Contiguous-region allocator with free and owned extent tables.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | vpa_in_t  (opcode, size, owner)
//  out_    | output    | out_valid/out_stall| vpa_out_t (status, id, base)
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A create scans the owned table (one entry per cycle), then the free
// table entry by entry plus a commit step, through one shared compare unit;
// a full owned table skips the free scan, and a bad size skips both scans.
// A kill scans the owned table, then the free table for neighbors, then for
// an empty entry when no merge applies; an unknown owner ends after the
// owned scan. The next item is taken the cycle after the result leaves.
// Synchronous active-low reset restores the tables (valid bits).
// The result waits in an output register; a new item is taken once it leaves.
// Configuration writes are taken only while idle; a pending write holds off
// the input.
module variable_partition_allocator (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  vpa_pkg::vpa_in_t       in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output vpa_pkg::vpa_out_t      out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_index,
  input  logic [15:0]            cfg_data
);

  localparam int AB = vpa_pkg::ADDR_BITS;
  localparam int OI = vpa_pkg::OWN_IDX_BITS;
  localparam int FI = vpa_pkg::FREE_IDX_BITS;
  localparam int OC = vpa_pkg::OWN_CNT_BITS;
  localparam int FC = vpa_pkg::FREE_CNT_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_OWN_SCAN, S_FIT_SCAN, S_NBR_SCAN, S_EMPTY_SCAN, S_DONE
  } state_t;

  state_t state_r;

  logic [1:0]    fit_r;
  logic [15:0]   total_r;
  logic [15:0]   last_r;
  vpa_pkg::vpa_in_t req_r;
  vpa_pkg::vpa_out_t res_r;
  logic          out_valid_r;

  logic [AB-1:0] fb_r  [vpa_pkg::FREE_ENTRIES];
  logic [AB-1:0] fl_r  [vpa_pkg::FREE_ENTRIES];
  logic [vpa_pkg::FREE_ENTRIES-1:0] fv_r;
  logic [15:0]   oid_r [vpa_pkg::OWNED_ENTRIES];
  logic [AB-1:0] ob_r  [vpa_pkg::OWNED_ENTRIES];
  logic [AB-1:0] ol_r  [vpa_pkg::OWNED_ENTRIES];
  logic [vpa_pkg::OWNED_ENTRIES-1:0] ov_r;

  logic [FC-1:0] fcnt_r;
  logic [OC-1:0] ocnt_r;
  logic          slot_ok_r, pick_ok_r, below_ok_r, above_ok_r;
  logic [OI-1:0] slot_r;
  logic [FI-1:0] pick_r, below_r, above_r;
  logic [AB-1:0] kb_r, kl_r;

  logic [FI-1:0] fi;
  logic [OI-1:0] oi;
  logic [AB-1:0] cur_b, cur_l, pk_b, pk_l, kend;
  logic          better;

  assign fi    = fcnt_r[FI-1:0];
  assign oi    = ocnt_r[OI-1:0];
  assign cur_b = fb_r[fi];
  assign cur_l = fl_r[fi];
  assign pk_b  = fb_r[pick_r];
  assign pk_l  = fl_r[pick_r];
  assign kend  = kb_r + kl_r;

  // Shared compare unit: is the current free entry a better pick?
  always_comb begin
    unique case (fit_r)
      vpa_pkg::FIT_WORST: better = (cur_l > pk_l) || (cur_l == pk_l && cur_b < pk_b);
      vpa_pkg::FIT_FIRST: better = cur_b < pk_b;
      default:            better = (cur_l < pk_l) || (cur_l == pk_l && cur_b < pk_b);
    endcase
  end

  // Hold the input off while busy, while a result waits or while a write is offered.
  assign in_stall  = (state_r != S_IDLE) || out_valid_r || cfg_valid;
  assign cfg_ready = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fit_r       <= vpa_pkg::FIT_BEST;
      total_r     <= vpa_pkg::RESET_TOTAL;
      last_r      <= '0;
      out_valid_r <= 1'b0;
      fv_r        <= {{(vpa_pkg::FREE_ENTRIES-1){1'b0}}, 1'b1};
      fb_r[0]     <= '0;
      fl_r[0]     <= AB'(vpa_pkg::RESET_TOTAL);
      ov_r        <= '0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (cfg_valid && cfg_ready) begin
            if (cfg_index == vpa_pkg::CFG_FIT_POLICY) begin
              fit_r <= cfg_data[1:0];
            end else begin
              // Reinitialize both tables around the new size.
              total_r <= cfg_data;
              fb_r[0] <= '0;
              fl_r[0] <= AB'(cfg_data);
              fv_r    <= {{(vpa_pkg::FREE_ENTRIES-1){1'b0}}, (cfg_data != 16'd0)};
              ov_r    <= '0;
            end
          end else if (in_valid && !in_stall) begin
            req_r      <= in_data;
            ocnt_r     <= '0;
            slot_ok_r  <= 1'b0;
            if (in_data.opcode == vpa_pkg::OP_CREATE) begin
              if (in_data.request_size == 16'd0 || in_data.request_size > total_r) begin
                res_r   <= '{vpa_pkg::ST_BAD_SIZE, 16'd0, 16'd0};
                state_r <= S_DONE;
              end else begin
                last_r  <= last_r + 16'd1;
                res_r   <= '{vpa_pkg::ST_FULL, last_r + 16'd1, 16'd0};
                state_r <= S_OWN_SCAN;
              end
            end else begin
              res_r   <= '{vpa_pkg::ST_UNKNOWN, in_data.target_owner, 16'd0};
              state_r <= S_OWN_SCAN;
            end
          end
        end
        S_OWN_SCAN: begin
          // Find the lowest free slot (create) or matching owner (kill).
          if (!slot_ok_r &&
              ((req_r.opcode == vpa_pkg::OP_CREATE && !ov_r[oi]) ||
               (req_r.opcode == vpa_pkg::OP_KILL && ov_r[oi] &&
                oid_r[oi] == req_r.target_owner))) begin
            slot_ok_r <= 1'b1;
            slot_r    <= oi;
          end
          if (ocnt_r == OC'(vpa_pkg::OWNED_ENTRIES - 1)) begin
            fcnt_r     <= '0;
            pick_ok_r  <= 1'b0;
            below_ok_r <= 1'b0;
            above_ok_r <= 1'b0;
            if (req_r.opcode == vpa_pkg::OP_CREATE) begin
              state_r <= (slot_ok_r || !ov_r[oi]) ? S_FIT_SCAN : S_DONE;
            end else if (slot_ok_r) begin
              kb_r <= ob_r[slot_r];
              kl_r <= ol_r[slot_r];
              ov_r[slot_r] <= 1'b0;
              state_r <= S_NBR_SCAN;
            end else if (ov_r[oi] && oid_r[oi] == req_r.target_owner) begin
              kb_r <= ob_r[oi];
              kl_r <= ol_r[oi];
              ov_r[oi] <= 1'b0;
              state_r <= S_NBR_SCAN;
            end else begin
              state_r <= S_DONE;
            end
          end else begin
            ocnt_r <= ocnt_r + OC'(1);
          end
        end
        S_FIT_SCAN: begin
          if (fcnt_r != FC'(vpa_pkg::FREE_ENTRIES) &&
              fv_r[fi] && cur_l >= AB'(req_r.request_size) &&
              (!pick_ok_r || better)) begin
            pick_ok_r <= 1'b1;
            pick_r    <= fi;
          end
          if (fcnt_r == FC'(vpa_pkg::FREE_ENTRIES)) begin
            // Commit: carve the low end of the chosen extent.
            if (!pick_ok_r) begin
              res_r.status <= vpa_pkg::ST_NO_FIT;
            end else begin
              oid_r[slot_r] <= res_r.owner_id;
              ob_r[slot_r]  <= pk_b;
              ol_r[slot_r]  <= AB'(req_r.request_size);
              ov_r[slot_r]  <= 1'b1;
              if (pk_l == AB'(req_r.request_size)) begin
                fv_r[pick_r] <= 1'b0;
              end else begin
                fb_r[pick_r] <= pk_b + AB'(req_r.request_size);
                fl_r[pick_r] <= pk_l - AB'(req_r.request_size);
              end
              res_r.status       <= vpa_pkg::ST_OK;
              res_r.base_address <= 16'(pk_b);
            end
            state_r <= S_DONE;
          end else begin
            fcnt_r <= fcnt_r + FC'(1);
          end
        end
        S_NBR_SCAN: begin
          if (fcnt_r == FC'(vpa_pkg::FREE_ENTRIES)) begin
            res_r.status       <= vpa_pkg::ST_OK;
            res_r.base_address <= 16'(kb_r);
            if (below_ok_r && above_ok_r) begin
              fl_r[below_r] <= fl_r[below_r] + kl_r + fl_r[above_r];
              fv_r[above_r] <= 1'b0;
              state_r <= S_DONE;
            end else if (below_ok_r) begin
              fl_r[below_r] <= fl_r[below_r] + kl_r;
              state_r <= S_DONE;
            end else if (above_ok_r) begin
              fb_r[above_r] <= kb_r;
              fl_r[above_r] <= fl_r[above_r] + kl_r;
              state_r <= S_DONE;
            end else begin
              fcnt_r  <= '0;
              state_r <= S_EMPTY_SCAN;
            end
          end else begin
            if (fv_r[fi]) begin
              if (!below_ok_r && cur_b + cur_l == kb_r) begin
                below_ok_r <= 1'b1;
                below_r    <= fi;
              end else if (!above_ok_r && cur_b == kend) begin
                above_ok_r <= 1'b1;
                above_r    <= fi;
              end
            end
            fcnt_r <= fcnt_r + FC'(1);
          end
        end
        S_EMPTY_SCAN: begin
          // Place the extent in the lowest empty entry; drop it if none.
          if (fcnt_r == FC'(vpa_pkg::FREE_ENTRIES)) begin
            state_r <= S_DONE;
          end else if (!fv_r[fi]) begin
            fv_r[fi] <= 1'b1;
            fb_r[fi] <= kb_r;
            fl_r[fi] <= kl_r;
            state_r  <= S_DONE;
          end else begin
            fcnt_r <= fcnt_r + FC'(1);
          end
        end
        S_DONE: begin
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("item accepted but sequencer stayed idle");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");
  a_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status <= vpa_pkg::ST_FULL))
    else $error("bad status code");
`endif

endmodule
